>>> rtl/core/qte_pkg.sv
// ============================================================================
// qte_pkg
// Types, constants and helper functions for the quaternion to Euler converter.
// ============================================================================
`default_nettype none

package qte_pkg;

    localparam int COMP_W     = 16;   // quaternion component width, Q2.14
    localparam int ANG_W      = 16;   // output angle width, Q4.12
    localparam int SCALE_W    = 33;   // sum of four Q28 squares
    localparam int TEST_W     = 34;   // x*y + z*w in Q28
    localparam int PROD_W     = 32;   // one Q28 product
    localparam int CMP_W      = 45;   // pole compare products
    localparam int CDW        = 36;   // CORDIC x/y width
    localparam int ZW         = 28;   // CORDIC angle width, Q24
    localparam int ATAN_N     = 24;
    localparam int DIV_STEPS  = 24;   // quotient bits of 2*|test|/scale in Q24
    localparam int RW         = 24;
    localparam int SQ_W       = 49;
    localparam int SQRT_STEPS = 25;

    localparam logic [1:0] CASE_NORMAL = 2'd0;
    localparam logic [1:0] CASE_NORTH  = 2'd1;
    localparam logic [1:0] CASE_SOUTH  = 2'd2;
    localparam logic [1:0] CASE_ZERO   = 2'd3;

    localparam logic signed [ZW-1:0]    HALF_PI_Q24  = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] POLE_ATT_Q12 = 16'sd6431;

    localparam logic signed [ZW-1:0] ATAN_Q24 [0:ATAN_N-1] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [ANG_W-1:0] bank_angle;
        logic signed [ANG_W-1:0] heading_angle;
        logic signed [ANG_W-1:0] attitude_angle;
        logic        [1:0]       pole_case;
    } t_euler;

    typedef struct packed {
        logic signed [CDW-1:0] x;
        logic signed [CDW-1:0] y;
        logic signed [ZW-1:0]  z;
    } t_cordic;

    typedef struct packed {
        logic [SCALE_W-1:0] rem;
        logic [SCALE_W-1:0] dvs;
        logic [RW-1:0]      quo;
    } t_div;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [1:0] code;
        logic       neg;
    } t_side;

    // Turn an operand in the left half plane by a quarter turn.
    function automatic t_cordic f_pre(input logic signed [CDW-1:0] y,
                                      input logic signed [CDW-1:0] x);
        t_cordic c;
        c.x = x;
        c.y = y;
        c.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                c.x = y;
                c.y = -x;
                c.z = HALF_PI_Q24;
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -HALF_PI_Q24;
            end
        end
        return c;
    endfunction

    // Round half up from Q24 to Q12, then saturate.
    function automatic logic signed [ANG_W-1:0] f_to_q12(input logic signed [ZW+1:0] z);
        logic signed [ZW+2:0] s;
        logic signed [ZW+2:0] v;
        s = (ZW+3)'(z) + (ZW+3)'(2048);
        v = s >>> 12;
        if (v > (ZW+3)'(32767)) begin
            v = (ZW+3)'(32767);
        end else if (v < -(ZW+3)'(32768)) begin
            v = -(ZW+3)'(32768);
        end
        return v[ANG_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/qte_div_cell.sv
// ============================================================================
// qte_div_cell
// One restoring division step: one quotient bit per cell.
// ============================================================================
`default_nettype none

module qte_div_cell
    import qte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_div i_d,
    output t_div      o_d
);

    logic [SCALE_W:0]   n_t;
    logic               n_ge;
    logic [SCALE_W-1:0] n_rem;

    always_comb begin
        n_t   = {i_d.rem, 1'b0};
        n_ge  = (n_t >= {1'b0, i_d.dvs});
        n_rem = n_ge ? SCALE_W'(n_t - {1'b0, i_d.dvs}) : n_t[SCALE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d.rem <= n_rem;
            o_d.dvs <= i_d.dvs;
            o_d.quo <= {i_d.quo[RW-2:0], n_ge};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/qte_sqrt_cell.sv
// ============================================================================
// qte_sqrt_cell
// One digit step of a floored integer square root.
// ============================================================================
`default_nettype none

module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int BIT_POS = 48
) (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_sqrt i_s,
    output t_sqrt      o_s
);

    localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << BIT_POS;

    logic [SQ_W:0] n_sum;
    logic          n_ge;

    always_comb begin
        n_sum = {1'b0, i_s.res} + {1'b0, BIT_VAL};
        n_ge  = ({1'b0, i_s.v} >= n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_ge) begin
                o_s.v   <= i_s.v - n_sum[SQ_W-1:0];
                o_s.res <= (i_s.res >> 1) + BIT_VAL;
            end else begin
                o_s.v   <= i_s.v;
                o_s.res <= i_s.res >> 1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/qte_cordic_cell.sv
// ============================================================================
// qte_cordic_cell
// One vectoring CORDIC micro-rotation; holds once the residual is zero.
// ============================================================================
`default_nettype none

module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire logic    i_clk,
    input  wire logic    i_en,
    input  wire t_cordic i_c,
    output t_cordic      o_c
);

    logic signed [CDW-1:0] n_dx;
    logic signed [CDW-1:0] n_dy;

    always_comb begin
        n_dx = i_c.y >>> SHIFT;
        n_dy = i_c.x >>> SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_c.y == '0) begin
                o_c <= i_c;
            end else if (i_c.y > 0) begin
                o_c.x <= i_c.x + n_dx;
                o_c.y <= i_c.y - n_dy;
                o_c.z <= i_c.z + ATAN_Q24[SHIFT];
            end else begin
                o_c.x <= i_c.x - n_dx;
                o_c.y <= i_c.y + n_dy;
                o_c.z <= i_c.z - ATAN_Q24[SHIFT];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/quaternion_to_euler_top.sv
// ============================================================================
// quaternion_to_euler_top
// Converts a quaternion into bank, heading and attitude angles.
// ============================================================================
// Input channel: i_valid / o_stall with payload i_quat (w, x, y, z, Q2.14).
// Output channel: o_valid / i_stall with payload o_euler (three Q4.12 angles
// in radians and the pole case code).
// A transaction moves on a rising edge with valid high and stall low.
// Throughput is one transaction per cycle while the output is not stalled, set
// by a fully pipelined chain: product and compare stages, 24 divider cells, a
// square stage, 25 square-root cells and three rows of CORDIC cells.
// The output register is backed by one skid entry; when the receiver stalls
// and another result arrives, the skid fills and the whole chain holds, with
// o_stall raised for as long as the skid is full. Reset clears all valid
// flags; no clearing pass is needed.
// ============================================================================
`default_nettype none

module quaternion_to_euler_top
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_stall,
    input  wire t_quat  i_quat,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_euler      o_euler
);

    localparam int IDX_M    = DIV_STEPS + 1;
    localparam int IDX_SQ   = DIV_STEPS + SQRT_STEPS + 2;
    localparam int LAST     = IDX_SQ + 1 + CORDIC_STAGES;
    localparam int HB_DLY   = LAST - CORDIC_STAGES;
    localparam int RQ_LEN   = IDX_SQ - IDX_M + 1;

    logic en;

    // Front stages
    logic r_v1, r_v2, r_v3, r_v4;
    t_quat r1_q;
    logic signed [PROD_W-1:0] r2_sw, r2_sx, r2_sy, r2_sz;
    logic signed [PROD_W-1:0] r2_xy, r2_zw, r2_yw, r2_xz, r2_xw, r2_yz;
    logic signed [COMP_W-1:0] r2_x, r2_w, r3_x, r3_w, r4_x, r4_w;
    logic [SCALE_W-1:0]       r3_scale, r4_scale;
    logic signed [TEST_W-1:0] r3_test;
    logic signed [CDW-1:0]    r3_hy, r3_hx, r3_by, r3_bx;
    logic signed [CDW-1:0]    r4_hy, r4_hx, r4_by, r4_bx;
    logic signed [CMP_W-1:0]  r4_pt, r4_ps;
    logic [PROD_W-1:0]        r4_abs;
    logic                     r4_neg;

    logic [LAST:0] r_sbv;
    t_side         r_sb [0:LAST];
    t_side         n_sb;

    t_cordic r_head0, r_bank0, r_att0;
    t_div    r_div0;
    t_sqrt   r_sq0;
    logic [2*RW-1:0] r_rr;
    logic [RW-1:0]   r_rq [0:RQ_LEN-1];
    logic signed [ZW-1:0] r_hz [0:HB_DLY-1];
    logic signed [ZW-1:0] r_bz [0:HB_DLY-1];

    t_cordic w_head [0:CORDIC_STAGES];
    t_cordic w_bank [0:CORDIC_STAGES];
    t_cordic w_att  [0:CORDIC_STAGES];
    t_div    w_div  [0:DIV_STEPS];
    t_sqrt   w_sq   [0:SQRT_STEPS];

    logic signed [CDW-1:0] n_hy, n_hx, n_by, n_bx;
    logic signed [CDW-1:0] n_ay;

    logic   r_out_vld, r_skid_vld;
    t_euler r_out, r_skid, n_res;

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_euler = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_sbv <= '0;
        end else if (en) begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_sbv <= {r_sbv[LAST-1:0], r_v4};
        end
    end

    // Products, sums and pole compare products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_q  <= i_quat;

            r2_sw <= PROD_W'(r1_q.quat_w) * PROD_W'(r1_q.quat_w);
            r2_sx <= PROD_W'(r1_q.quat_x) * PROD_W'(r1_q.quat_x);
            r2_sy <= PROD_W'(r1_q.quat_y) * PROD_W'(r1_q.quat_y);
            r2_sz <= PROD_W'(r1_q.quat_z) * PROD_W'(r1_q.quat_z);
            r2_xy <= PROD_W'(r1_q.quat_x) * PROD_W'(r1_q.quat_y);
            r2_zw <= PROD_W'(r1_q.quat_z) * PROD_W'(r1_q.quat_w);
            r2_yw <= PROD_W'(r1_q.quat_y) * PROD_W'(r1_q.quat_w);
            r2_xz <= PROD_W'(r1_q.quat_x) * PROD_W'(r1_q.quat_z);
            r2_xw <= PROD_W'(r1_q.quat_x) * PROD_W'(r1_q.quat_w);
            r2_yz <= PROD_W'(r1_q.quat_y) * PROD_W'(r1_q.quat_z);
            r2_x  <= r1_q.quat_x;
            r2_w  <= r1_q.quat_w;

            r3_scale <= SCALE_W'(r2_sw) + SCALE_W'(r2_sx) + SCALE_W'(r2_sy)
                      + SCALE_W'(r2_sz);
            r3_test  <= TEST_W'(r2_xy) + TEST_W'(r2_zw);
            r3_hy    <= n_hy;
            r3_hx    <= n_hx;
            r3_by    <= n_by;
            r3_bx    <= n_bx;
            r3_x     <= r2_x;
            r3_w     <= r2_w;

            r4_pt    <= CMP_W'(r3_test) * 45'sd1000;
            r4_ps    <= $signed(CMP_W'(r3_scale)) * 45'sd499;
            r4_abs   <= (r3_test < 0) ? PROD_W'(-r3_test) : PROD_W'(r3_test);
            r4_neg   <= (r3_test < 0);
            r4_scale <= r3_scale;
            r4_hy    <= r3_hy;
            r4_hx    <= r3_hx;
            r4_by    <= r3_by;
            r4_bx    <= r3_bx;
            r4_x     <= r3_x;
            r4_w     <= r3_w;
        end
    end

    always_comb begin
        n_hy = (CDW'(r2_yw) - CDW'(r2_xz)) <<< 1;
        n_hx = CDW'(r2_sx) - CDW'(r2_sy) - CDW'(r2_sz) + CDW'(r2_sw);
        n_by = (CDW'(r2_xw) - CDW'(r2_yz)) <<< 1;
        n_bx = CDW'(r2_sy) - CDW'(r2_sx) - CDW'(r2_sz) + CDW'(r2_sw);
    end

    // Case decision
    always_comb begin
        n_sb.neg = r4_neg;
        if (r4_scale == '0) begin
            n_sb.code = CASE_ZERO;
        end else if (r4_pt > r4_ps) begin
            n_sb.code = CASE_NORTH;
        end else if (r4_pt < -r4_ps) begin
            n_sb.code = CASE_SOUTH;
        end else begin
            n_sb.code = CASE_NORMAL;
        end
    end

    // Chain entry registers and side lines
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (n_sb.code == CASE_NORTH || n_sb.code == CASE_SOUTH) begin
                r_head0 <= f_pre(CDW'(r4_x), CDW'(r4_w));
            end else begin
                r_head0 <= f_pre(r4_hy, r4_hx);
            end
            r_bank0    <= f_pre(r4_by, r4_bx);
            r_div0.rem <= {r4_abs, 1'b0};
            r_div0.dvs <= r4_scale;
            r_div0.quo <= '0;

            r_sb[0] <= n_sb;
            for (int k = 1; k <= LAST; k++) begin
                r_sb[k] <= r_sb[k-1];
            end

            r_rq[0] <= w_div[DIV_STEPS].quo;
            r_rr    <= w_div[DIV_STEPS].quo * w_div[DIV_STEPS].quo;
            for (int k = 1; k < RQ_LEN; k++) begin
                r_rq[k] <= r_rq[k-1];
            end
            r_sq0.v   <= (SQ_W'(1) << (2 * RW)) - SQ_W'(r_rr);
            r_sq0.res <= '0;

            r_att0 <= f_pre(n_ay, CDW'(w_sq[SQRT_STEPS].res));

            r_hz[0] <= w_head[CORDIC_STAGES].z;
            r_bz[0] <= w_bank[CORDIC_STAGES].z;
            for (int k = 1; k < HB_DLY; k++) begin
                r_hz[k] <= r_hz[k-1];
                r_bz[k] <= r_bz[k-1];
            end
        end
    end

    always_comb begin
        if (r_sb[IDX_SQ].neg) begin
            n_ay = -CDW'(r_rq[RQ_LEN-1]);
        end else begin
            n_ay = CDW'(r_rq[RQ_LEN-1]);
        end
    end

    assign w_head[0] = r_head0;
    assign w_bank[0] = r_bank0;
    assign w_att[0]  = r_att0;
    assign w_div[0]  = r_div0;
    assign w_sq[0]   = r_sq0;

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
            qte_cordic_cell #(.SHIFT(gi)) u_head (
                .i_clk (i_clk),
                .i_en  (en),
                .i_c   (w_head[gi]),
                .o_c   (w_head[gi+1])
            );
            qte_cordic_cell #(.SHIFT(gi)) u_bank (
                .i_clk (i_clk),
                .i_en  (en),
                .i_c   (w_bank[gi]),
                .o_c   (w_bank[gi+1])
            );
            qte_cordic_cell #(.SHIFT(gi)) u_att (
                .i_clk (i_clk),
                .i_en  (en),
                .i_c   (w_att[gi]),
                .o_c   (w_att[gi+1])
            );
        end
        for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
            qte_div_cell u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (w_div[gi]),
                .o_d   (w_div[gi+1])
            );
        end
        for (gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
            qte_sqrt_cell #(.BIT_POS(2 * RW - 2 * gi)) u_sqrt (
                .i_clk (i_clk),
                .i_en  (en),
                .i_s   (w_sq[gi]),
                .o_s   (w_sq[gi+1])
            );
        end
    endgenerate

    // Result assembly
    always_comb begin
        n_res.pole_case = r_sb[LAST].code;
        case (r_sb[LAST].code)
            CASE_NORMAL: begin
                n_res.bank_angle     = f_to_q12((ZW+2)'(r_bz[HB_DLY-1]));
                n_res.heading_angle  = f_to_q12((ZW+2)'(r_hz[HB_DLY-1]));
                n_res.attitude_angle = f_to_q12((ZW+2)'(w_att[CORDIC_STAGES].z));
            end
            CASE_NORTH: begin
                n_res.bank_angle     = '0;
                n_res.heading_angle  = f_to_q12((ZW+2)'(r_hz[HB_DLY-1]) <<< 1);
                n_res.attitude_angle = POLE_ATT_Q12;
            end
            CASE_SOUTH: begin
                n_res.bank_angle     = '0;
                n_res.heading_angle  = f_to_q12(-((ZW+2)'(r_hz[HB_DLY-1]) <<< 1));
                n_res.attitude_angle = -POLE_ATT_Q12;
            end
            default: begin
                n_res.bank_angle     = '0;
                n_res.heading_angle  = '0;
                n_res.attitude_angle = '0;
            end
        endcase
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_stall) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || !i_stall) begin
            r_out_vld <= r_sbv[LAST];
        end else if (r_sbv[LAST]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || !i_stall) begin
            r_out <= n_res;
        end else begin
            r_skid <= n_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/qte_checker.sv
// ============================================================================
// qte_checker
// Port-level checks for the quaternion to Euler converter.
// ============================================================================
`default_nettype none

module qte_port_checker
    import qte_pkg::*;
(
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   o_valid,
    input wire logic   i_stall,
    input wire t_euler o_euler
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transaction dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_euler))
        else $error("stalled output payload changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_euler.pole_case == CASE_ZERO |->
            o_euler.bank_angle == '0 && o_euler.heading_angle == '0
            && o_euler.attitude_angle == '0)
        else $error("zero quaternion with nonzero angle");

    a_pole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_euler.pole_case == CASE_NORTH || o_euler.pole_case == CASE_SOUTH)
            |-> o_euler.bank_angle == '0
            && (o_euler.attitude_angle == POLE_ATT_Q12
                || o_euler.attitude_angle == -POLE_ATT_Q12))
        else $error("pole result with wrong bank or attitude");

endmodule

bind quaternion_to_euler_top qte_port_checker u_qte_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_euler (o_euler)
);

`default_nettype wire
